FILE: hw/rtl/min_coin_change_top_defines.svh
// Assertion macros for the minimum-coin change block
`ifndef MIN_COIN_CHANGE_TOP_DEFINES_SVH
`define MIN_COIN_CHANGE_TOP_DEFINES_SVH
// property that holds in the cycle after an antecedent
`define MCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
// property that holds in the same cycle
`define MCC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/mcc_pkg.sv
// Shared types and constants for the minimum-coin change block
package mcc_pkg;
  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_LOAD   = 10'b0000000010,
    ST_SINIT  = 10'b0000000100,
    ST_COIN   = 10'b0000001000,
    ST_WAIT   = 10'b0000010000,
    ST_STORE  = 10'b0000100000,
    ST_BTRD   = 10'b0001000000,
    ST_BTUSE  = 10'b0010000000,
    ST_EMIT   = 10'b0100000000,
    ST_INF    = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic load_shift;   // one step of insertion shift
    logic load_start;
    logic s_init;
    logic coin_eval;
    logic s_store;
    logic bt_init;
    logic bt_read;
    logic bt_use;
    logic emit;
    logic emit_inf;
  } cmd_t;

  typedef struct packed {
    logic load_done;
    logic list_empty;
    logic amt_bad;
    logic coin_last;
    logic exact_hit;
    logic s_last;
    logic s_fail;
    logic bt_done;
    logic emit_last;
  } sts_t;
endpackage

FILE: hw/rtl/min_coin_change_top.sv
// Top level of the minimum-coin change block
// Usage:
//  Items enter on start when busy is low. func 0 loads one coin
//  (first_coin clears the list first); func 1 computes change for amount.
//  A load keeps busy high while coins shift to make room for the new
//  one, and gives no result.
//  A compute passes a set-up state, then per sub-amount a fetch and an
//  evaluate state for each coin tried and then a store state; the pass
//  is set by one read of the fewest-coins memory per coin tried.
//  The backtrack reads and uses the chosen coins one by one, then each
//  result is formed while tallies of equal values are summed.
//  Results appear one per loaded coin, descending, each for one cycle
//  with strobe high; last marks the final one, shown in the first cycle
//  with busy low. Infeasible amounts give a single result with feasible low.
//  Reset empties the coin list; tables need no clearing.
//  The receiver cannot stall; results are never held.
`include "min_coin_change_top_defines.svh"
module min_coin_change_top #(
  parameter int MAX_COINS  = 16,
  parameter int MAX_AMOUNT = 1023,
  parameter int COIN_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic        first_coin,
  input  logic [15:0] coin_value,
  input  logic [9:0]  amount,
  output logic        strobe,
  output logic [15:0] denomination,
  output logic [9:0]  coin_count,
  output logic        feasible,
  output logic        last
);
  mcc_pkg::cmd_t cmd;
  mcc_pkg::sts_t sts;

  mcc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start && !busy), .func(func),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  mcc_dp #(.MAX_COINS(MAX_COINS), .MAX_AMOUNT(MAX_AMOUNT), .COIN_BITS(COIN_BITS)) u_dp (
    .clk(clk), .rst(rst), .first_coin(first_coin), .coin_value(coin_value),
    .amount(amount), .cmd(cmd), .sts(sts), .denomination(denomination),
    .coin_count(coin_count), .feasible(feasible), .last(last), .strobe(strobe)
  );

  `MCC_ASSERT_NEXT(a_inf_strobe, clk, rst, cmd.emit_inf, strobe && last && !feasible)
  `MCC_ASSERT_NOW(a_strobe_busy, clk, rst, strobe && !last, busy)
  `MCC_ASSERT_NOW(a_one_cmd, clk, rst, 1'b1, $onehot0({cmd.emit, cmd.emit_inf, cmd.coin_eval}))
endmodule

FILE: hw/rtl/mcc_ctrl.sv
// Controller state machine for the minimum-coin change block
module mcc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          func,
  input  mcc_pkg::sts_t sts,
  output mcc_pkg::cmd_t cmd,
  output logic          busy
);
  mcc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= mcc_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      mcc_pkg::ST_IDLE: begin
        if (start) begin
          if (!func) begin
            cmd.load_start = 1'b1;
            state_next = mcc_pkg::ST_LOAD;
          end else if (sts.list_empty || sts.amt_bad) begin
            state_next = mcc_pkg::ST_INF;
          end else begin
            cmd.s_init = 1'b1;
            state_next = mcc_pkg::ST_SINIT;
          end
        end
      end
      mcc_pkg::ST_LOAD: begin
        cmd.load_shift = 1'b1;
        if (sts.load_done) state_next = mcc_pkg::ST_IDLE;
      end
      mcc_pkg::ST_SINIT: state_next = mcc_pkg::ST_COIN;
      mcc_pkg::ST_COIN: begin
        cmd.coin_eval = 1'b1;
        state_next = mcc_pkg::ST_WAIT;
      end
      mcc_pkg::ST_WAIT: begin
        if (sts.exact_hit || sts.coin_last) state_next = mcc_pkg::ST_STORE;
        else state_next = mcc_pkg::ST_COIN;
      end
      mcc_pkg::ST_STORE: begin
        cmd.s_store = 1'b1;
        if (sts.s_last) begin
          if (sts.s_fail) state_next = mcc_pkg::ST_INF;
          else begin
            cmd.bt_init = 1'b1;
            state_next = mcc_pkg::ST_BTRD;
          end
        end else state_next = mcc_pkg::ST_COIN;
      end
      mcc_pkg::ST_BTRD: begin
        if (sts.bt_done) state_next = mcc_pkg::ST_EMIT;
        else begin
          cmd.bt_read = 1'b1;
          state_next = mcc_pkg::ST_BTUSE;
        end
      end
      mcc_pkg::ST_BTUSE: begin
        cmd.bt_use = 1'b1;
        state_next = mcc_pkg::ST_BTRD;
      end
      mcc_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_last) state_next = mcc_pkg::ST_IDLE;
      end
      mcc_pkg::ST_INF: begin
        cmd.emit_inf = 1'b1;
        state_next = mcc_pkg::ST_IDLE;
      end
      default: state_next = mcc_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state != mcc_pkg::ST_IDLE);
endmodule

FILE: hw/rtl/mcc_dp.sv
// Datapath for the minimum-coin change block: coin list, tables, tallies
module mcc_dp #(
  parameter int MAX_COINS  = 16,
  parameter int MAX_AMOUNT = 1023,
  parameter int COIN_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          first_coin,
  input  logic [15:0]   coin_value,
  input  logic [9:0]    amount,
  input  mcc_pkg::cmd_t cmd,
  output mcc_pkg::sts_t sts,
  output logic [15:0]   denomination,
  output logic [9:0]    coin_count,
  output logic          feasible,
  output logic          last,
  output logic          strobe
);
  localparam int IW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int TW = $clog2(MAX_COINS + 1);
  localparam int AW = $clog2(MAX_AMOUNT + 1);
  localparam int FW = AW + 1;

  logic [COIN_BITS-1:0] coin_list [MAX_COINS];
  logic [TW-1:0]        coin_total;
  logic [FW-1:0]        fewest [MAX_AMOUNT+1];
  logic [IW-1:0]        chosen [MAX_AMOUNT+1];
  logic [9:0]           tally [MAX_COINS];

  // insertion
  logic [COIN_BITS-1:0] new_v;
  logic [TW-1:0]        ins_k;
  logic                 ins_active;
  logic [TW-1:0]        base_total;

  always_comb begin
    base_total = first_coin ? '0 : coin_total;
  end

  assign sts.load_done  = !ins_active || (ins_k == '0) ||
                          (coin_list[ins_k[IW-1:0] - 1'b1] >= new_v);
  assign sts.list_empty = (coin_total == '0);
  assign sts.amt_bad    = (amount == '0) || (32'(amount) > MAX_AMOUNT);

  // compute state
  logic [AW-1:0] s, amt;
  logic [TW-1:0] k;
  logic [FW-1:0] best;
  logic [IW-1:0] pick;
  logic          hit;
  logic          rd_ok;
  logic [FW-1:0] f_rd;
  logic [IW-1:0] ch_rd;
  logic [AW-1:0] rest;
  logic [AW:0]   guard;
  logic          bt_stop;
  logic [IW-1:0] e_k;
  logic [9:0]    e_sum;
  logic [TW-1:0] e_j;
  logic [COIN_BITS-1:0] cur;
  // evaluation of the previously fetched coin happens in the WAIT cycle
  logic          eval_now;
  logic [FW-1:0] best_n;
  logic [IW-1:0] pick_n;

  assign cur = coin_list[k[IW-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.coin_eval) begin
      rd_ok <= (32'(cur) < 32'(s));
      hit <= (32'(cur) == 32'(s));
      f_rd <= fewest[AW'(32'(s) - 32'(cur))];
    end
    if (cmd.bt_read) ch_rd <= chosen[rest];
  end

  logic [FW:0] f1;
  assign f1 = {1'b0, f_rd} + 1'b1;
  assign sts.exact_hit = hit;
  assign sts.coin_last = (k == coin_total);
  assign sts.s_last    = (s == amt);
  assign sts.s_fail    = (best == '0);
  assign sts.bt_done   = bt_stop || (rest == '0) || (32'(guard) > MAX_AMOUNT);
  assign sts.emit_last = (e_k == IW'(coin_total - 1'b1)) && (e_j == coin_total);

  logic [COIN_BITS-1:0] bc;
  assign bc = coin_list[ch_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      coin_total <= '0;
      ins_active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_inf || (cmd.emit && (e_j == coin_total));
      if (cmd.load_start) begin
        new_v <= COIN_BITS'(coin_value);
        coin_total <= base_total;
        ins_k <= base_total;
        ins_active <= (32'(base_total) < MAX_COINS);
      end
      if (cmd.load_shift) begin
        if (ins_active) begin
          if (sts.load_done) begin
            coin_list[ins_k[IW-1:0]] <= new_v;
            coin_total <= coin_total + 1'b1;
            ins_active <= 1'b0;
          end else begin
            coin_list[ins_k[IW-1:0]] <= coin_list[ins_k[IW-1:0] - 1'b1];
            ins_k <= ins_k - 1'b1;
          end
        end
      end
      if (cmd.s_init) begin
        amt <= AW'(amount);
        s <= AW'(1);
        k <= '0;
        best <= '0;
        pick <= '0;
      end
      if (cmd.coin_eval) k <= k + 1'b1;
      if (cmd.s_store) begin
        fewest[s] <= best_n;
        chosen[s] <= pick_n;
        s <= s + 1'b1;
        k <= '0;
        best <= '0;
        pick <= '0;
      end else if (eval_now) begin
        best <= best_n;
        pick <= pick_n;
      end
      if (cmd.bt_init) begin
        rest <= amt;
        bt_stop <= 1'b0;
        guard <= '0;
        for (int i = 0; i < MAX_COINS; i++) tally[i] <= '0;
        e_k <= '0;
        e_j <= '0;
        e_sum <= '0;
      end
      if (cmd.bt_use) begin
        if (32'(ch_rd) >= 32'(coin_total) || bc == '0 || 32'(bc) > 32'(rest))
          bt_stop <= 1'b1;
        else begin
          tally[ch_rd] <= tally[ch_rd] + 1'b1;
          rest <= AW'(32'(rest) - 32'(bc));
          guard <= guard + 1'b1;
        end
      end
      if (cmd.emit) begin
        if (e_j == coin_total) begin
          denomination <= 16'(coin_list[e_k]);
          coin_count <= e_sum;
          feasible <= 1'b1;
          last <= sts.emit_last;
          e_k <= e_k + 1'b1;
          e_j <= '0;
          e_sum <= '0;
        end else begin
          if (coin_list[e_j[IW-1:0]] == coin_list[e_k]) e_sum <= e_sum + tally[e_j[IW-1:0]];
          e_j <= e_j + 1'b1;
        end
      end
      if (cmd.emit_inf) begin
        denomination <= '0;
        coin_count <= '0;
        feasible <= 1'b0;
        last <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) eval_now <= 1'b0;
    else eval_now <= cmd.coin_eval;
  end
  always_comb begin
    best_n = best;
    pick_n = pick;
    if (eval_now) begin
      if (hit) begin
        best_n = FW'(1);
        pick_n = IW'(k - 1'b1);
      end else if (rd_ok && f_rd != '0 && (best == '0 || f1 < {1'b0, best})) begin
        best_n = f1[FW-1:0];
        pick_n = IW'(k - 1'b1);
      end
    end
  end
endmodule

FILE: tb/mcc_checker.sv
// Checker for the minimum-coin change block: predicts results and compares them
module mcc_checker #(
  parameter int MAX_COINS  = 16,
  parameter int MAX_AMOUNT = 1023
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        func,
  input  logic        first_coin,
  input  logic [15:0] coin_value,
  input  logic [9:0]  amount,
  input  logic        strobe,
  input  logic [15:0] denomination,
  input  logic [9:0]  coin_count,
  input  logic        feasible,
  input  logic        last,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] denom;
    logic [9:0]  cnt;
    logic        feas;
    logic        fin;
  } change_t;

  change_t     results_due[$];
  int unsigned coins[MAX_COINS];
  int unsigned coins_held;
  int unsigned fewest[0:MAX_AMOUNT];
  int unsigned choice[0:MAX_AMOUNT];
  int unsigned used[MAX_COINS];

  function automatic void due_add(change_t r);
    results_due.insert(results_due.size(), r);
  endfunction

  function automatic void load_denomination(logic clr, logic [15:0] v);
    int unsigned pos;
    if (clr) coins_held = 0;
    if (coins_held >= MAX_COINS) return;
    pos = 0;
    while (pos < coins_held && coins[pos] >= v) pos++;
    for (int k = coins_held; k > pos; k--) coins[k] = coins[k-1];
    coins[pos] = v;
    coins_held++;
  endfunction

  function automatic void no_change();
    due_add('{16'd0, 10'd0, 1'b0, 1'b1});
  endfunction

  function automatic void change_for(int unsigned amt);
    int unsigned best, pick, rest, guard, idx, sum;
    if (coins_held == 0 || amt == 0 || amt > MAX_AMOUNT) begin
      no_change();
      return;
    end
    fewest[0] = 0;
    for (int unsigned s = 1; s <= amt; s++) begin
      best = 0;
      pick = 0;
      for (int unsigned k = 0; k < coins_held; k++) begin
        if (coins[k] == s) begin
          best = 1;
          pick = k;
          break;
        end
        if (coins[k] < s && fewest[s - coins[k]] != 0 &&
            (best == 0 || fewest[s - coins[k]] + 1 < best)) begin
          best = fewest[s - coins[k]] + 1;
          pick = k;
        end
      end
      fewest[s] = best;
      choice[s] = pick;
    end
    if (fewest[amt] == 0) begin
      no_change();
      return;
    end
    for (int k = 0; k < MAX_COINS; k++) used[k] = 0;
    rest = amt;
    guard = 0;
    while (rest > 0 && guard <= MAX_AMOUNT) begin
      idx = choice[rest];
      if (idx >= coins_held) break;
      if (coins[idx] == 0 || coins[idx] > rest) break;
      used[idx]++;
      rest -= coins[idx];
      guard++;
    end
    for (int unsigned k = 0; k < coins_held; k++) begin
      sum = 0;
      for (int unsigned j = 0; j < coins_held; j++)
        if (coins[j] == coins[k]) sum += used[j];
      due_add('{coins[k][15:0], sum[9:0], 1'b1, (k + 1 == coins_held)});
    end
  endfunction

  always @(posedge clk) begin
    change_t want;
    if (rst) begin
      coins_held = 0;
      fails = 0;
      results_due.delete();
    end else begin
      if (strobe) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected item denom=%0d count=%0d feasible=%0b last=%0b",
                   $time, denomination, coin_count, feasible, last);
          fails++;
        end else begin
          want = results_due.pop_front();
          if (denomination !== want.denom || coin_count !== want.cnt ||
              feasible !== want.feas || last !== want.fin) begin
            $display("%0t: expected denom=%0d count=%0d feasible=%0b last=%0b",
                     $time, want.denom, want.cnt, want.feas, want.fin);
            $display("%0t: actual   denom=%0d count=%0d feasible=%0b last=%0b",
                     $time, denomination, coin_count, feasible, last);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        if (func) change_for(amount);
        else load_denomination(first_coin, coin_value);
      end
    end
    pending = results_due.size();
  end
endmodule

FILE: tb/tb_top.sv
// Testbench top for the minimum-coin change block: stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FN_LOAD    = 1'b0;
  localparam logic FN_COMPUTE = 1'b1;
  localparam int   WATCHDOG   = 400000;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        func = 1'b0;
  logic        first_coin = 1'b0;
  logic [15:0] coin_value = '0;
  logic [9:0]  amount = '0;
  logic        busy, strobe, feasible, last;
  logic [15:0] denomination;
  logic [9:0]  coin_count;
  int          fails, pending;
  int          idle_cycles = 0;
  int          sent = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  min_coin_change_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .first_coin(first_coin), .coin_value(coin_value), .amount(amount),
    .strobe(strobe), .denomination(denomination), .coin_count(coin_count),
    .feasible(feasible), .last(last)
  );

  mcc_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .first_coin(first_coin), .coin_value(coin_value), .amount(amount),
    .strobe(strobe), .denomination(denomination), .coin_count(coin_count),
    .feasible(feasible), .last(last), .fails(fails), .pending(pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || strobe || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("min_coin_change_top: mismatch");
      $finish;
    end
  end

  // random pause: mostly none or short, now and then long
  task automatic pause();
    int n;
    n = ($urandom_range(0, 9) < 5) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 150);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue(logic f, logic fc, logic [15:0] cv, logic [9:0] am);
    start      <= 1'b1;
    func       <= f;
    first_coin <= fc;
    coin_value <= cv;
    amount     <= am;
    do @(negedge clk); while (busy);
    @(posedge clk);
    sent++;
    pause();
  endtask

  task automatic load(logic fc, logic [15:0] cv);
    issue(FN_LOAD, fc, cv, 10'($urandom));
  endtask

  task automatic compute(logic [9:0] am);
    issue(FN_COMPUTE, 1'($urandom), 16'($urandom), am);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coin();
    return ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 40)) : 16'($urandom);
  endfunction

  function automatic logic [9:0] pick_amount();
    int r;
    r = $urandom_range(0, 49);
    if (r == 0) return 10'd1023;
    if (r < 4) return 10'($urandom_range(0, 1023));
    return 10'($urandom_range(1, 120));
  endfunction

  initial begin
    int ncoins;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, amount zero, zero and widest coins, equal coins
    compute(10'd5);
    load(1'b1, 16'd1);
    compute(10'd0);
    load(1'b1, 16'hFFFF);
    load(1'b0, 16'd0);
    compute(10'd10);
    load(1'b1, 16'd1);
    load(1'b0, 16'd3);
    load(1'b0, 16'd4);
    compute(10'd6);
    load(1'b0, 16'd4);
    compute(10'd8);
    load(1'b1, 16'd2);
    compute(10'd7);
    drain();
    // full list, then one load too many, then the largest amount
    for (int k = 1; k <= 17; k++) load(k == 1, 16'(k * 3));
    compute(10'd1023);
    drain();

    while (sent < 100) begin
      if ($urandom_range(0, 9) < 8) begin
        ncoins = $urandom_range(1, 6);
        for (int k = 0; k < ncoins; k++) load(k == 0, pick_coin());
        repeat ($urandom_range(1, 3)) compute(pick_amount());
      end else if ($urandom_range(0, 1) == 0) begin
        load(1'($urandom), 16'($urandom));
      end else begin
        compute(10'($urandom));
      end
      if (sent > 70 && sent < 80) drain();
    end
    drain();
    repeat (50) @(posedge clk);

    if (fails == 0 && pending == 0) begin
      $display("min_coin_change_top: match");
    end else begin
      $display("min_coin_change_top: mismatch");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mcc_pkg.sv
hw/rtl/mcc_ctrl.sv
hw/rtl/mcc_dp.sv
hw/rtl/min_coin_change_top.sv
tb/mcc_checker.sv
tb/tb_top.sv
